// ===== rtl/core/spj_pkg.sv =====
// ----------------------------------------------------------------------------
// spj_pkg: shared types and constants of the spin jump observer
// Field widths, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package spj_pkg;

  localparam int unsigned StampW  = 48;
  localparam int unsigned PosW    = 16;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned DistW   = 16;
  localparam int unsigned LimitW  = 24;
  localparam int unsigned RatioW  = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 24;
  localparam int unsigned CntW    = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CfgJumpDistance = 2'd0,
    CfgPeriodLimit  = 2'd1,
    CfgFollowRatio  = 2'd2,
    CfgFireDelay    = 2'd3
  } cfg_idx_e;

  localparam logic [DistW-1:0]  JumpDistanceRst = DistW'(300);
  localparam logic [LimitW-1:0] PeriodLimitRst  = LimitW'(1000000);
  localparam logic [RatioW-1:0] FollowRatioRst  = RatioW'(128);
  localparam logic [LimitW-1:0] FireDelayRst    = LimitW'(100000);

  // follow ratio of exactly one in Q8.8
  localparam logic [RatioW-1:0] RatioOne = RatioW'(256);
  localparam logic [CntW-1:0]   CntSpin  = CntW'(2);

  typedef logic signed [PosW-1:0] pos_t;

endpackage

`default_nettype wire

// ===== rtl/core/spin_jump_observer.sv =====
// ----------------------------------------------------------------------------
// spin_jump_observer: spinning target detector
// Finds position jumps in a stream of tracked-target reports, measures the
// jump period and tells the aiming logic when to hold and when to fire.
//
// Input channel (in_valid_i / in_ready_o) takes one report word: stamp,
// x, y, z and a tracking flag. Output channel (out_valid_o / out_ready_i)
// gives one result word per report, in order.
// The report is captured in an input register, the checks and the state update
// are made combinationally from it, and the result lands in an output
// register. One report per cycle is sustained unless the receiver stalls; then
// the result holds in the output register and the input register still takes
// one more word, after which in_ready_o drops. The jump and spin state is
// updated together with the result, so each report sees the state left by the
// one before it. Reset clears the valid flags of both registers and the jump
// state and loads the default configuration. Configuration writes (cfg_we_i,
// cfg_idx_i, cfg_data_i) take effect at once and are to be made only while no
// report is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module spin_jump_observer (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [spj_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [spj_pkg::CfgW-1:0]       cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [spj_pkg::StampW-1:0]     stamp_us_i,
  input  wire logic signed [spj_pkg::PosW-1:0] pos_x_i,
  input  wire logic signed [spj_pkg::PosW-1:0] pos_y_i,
  input  wire logic signed [spj_pkg::PosW-1:0] pos_z_i,
  input  wire logic                           tracking_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic signed [spj_pkg::PosW-1:0]     out_x_o,
  output logic signed [spj_pkg::PosW-1:0]     out_y_o,
  output logic signed [spj_pkg::PosW-1:0]     out_z_o,
  output logic                                hold_and_zero_velocity_o,
  output logic                                suggest_fire_o,
  output logic                                spinning_o,
  output logic [spj_pkg::TimeW-1:0]           period_us_o,
  output logic [spj_pkg::TimeW-1:0]           since_jump_us_o
);
  import spj_pkg::*;

  // configuration
  logic [DistW-1:0]  jump_dist_q;
  logic [LimitW-1:0] period_limit_q;
  logic [RatioW-1:0] follow_ratio_q;
  logic [LimitW-1:0] fire_delay_q;

  // input register
  logic              s1_valid_q;
  logic [StampW-1:0] s1_stamp_q;
  pos_t              s1_pos_q [3];
  logic              s1_track_q;

  // jump state
  logic [StampW-1:0] last_jump_q, last_jump_d;
  pos_t              jump_pos_q [3];
  pos_t              jump_pos_d [3];
  pos_t              prev_pos_q [3];
  pos_t              prev_pos_d [3];
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              spin_q, spin_d;
  logic [TimeW-1:0]  period_q, period_d;

  // output register
  logic              out_valid_q;
  pos_t              res_pos_q [3];
  logic              hold_q;
  logic              fire_q;
  logic              spin_out_q;
  logic [TimeW-1:0]  period_out_q;
  logic [TimeW-1:0]  since_out_q;

  logic              advance;
  logic              in_accept;

  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign in_accept  = in_valid_i && in_ready_o;

  // time since last jump
  logic [StampW:0]   stamp_sub;
  logic [StampW-1:0] stamp_diff;
  logic [TimeW-1:0]  since;
  logic              expire;

  assign stamp_sub  = {1'b0, s1_stamp_q} - {1'b0, last_jump_q};
  assign stamp_diff = stamp_sub[StampW] ? '0 : stamp_sub[StampW-1:0];
  assign since      = (|stamp_diff[StampW-1:TimeW]) ? '1 : stamp_diff[TimeW-1:0];
  assign expire     = since > {{(TimeW-LimitW){1'b0}}, period_limit_q};

  // squared distance
  logic signed [PosW:0]     dpos [3];
  logic signed [2*PosW+1:0] dsq  [3];
  logic [2*PosW+1:0]        dist2;
  logic [2*DistW-1:0]       thr2;
  logic                     jump;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dpos[i] = $signed({s1_pos_q[i][PosW-1], s1_pos_q[i]})
              - $signed({prev_pos_q[i][PosW-1], prev_pos_q[i]});
      dsq[i]  = dpos[i] * dpos[i];
    end
  end

  assign dist2 = {2'b00, dsq[0][2*PosW-1:0]} + {2'b00, dsq[1][2*PosW-1:0]}
               + {2'b00, dsq[2][2*PosW-1:0]};
  assign thr2  = jump_dist_q * jump_dist_q;
  assign jump  = s1_track_q && (dist2 > {2'b00, thr2});

  // follow window against the stored period
  logic [StampW-1:0] follow_rhs;
  logic [StampW-1:0] follow_lhs;

  assign follow_rhs = StampW'(follow_ratio_q) * StampW'(period_q);
  assign follow_lhs = {{(StampW-TimeW-8){1'b0}}, since, 8'h00};

  // state update and result
  logic [CntW-1:0]        cnt_base;
  logic [CntW-1:0]        cnt_inc;
  logic                   spin_base;
  logic                   new_period;
  logic                   follow;
  logic                   hold;
  logic                   fire;
  logic signed [TimeW+1:0] fire_diff;
  pos_t                   res_pos [3];

  always_comb begin
    cnt_base    = expire ? '0 : cnt_q;
    spin_base   = expire ? 1'b0 : spin_q;
    cnt_inc     = (cnt_base < CntSpin) ? cnt_base + CntW'(1) : cnt_base;
    new_period  = jump && (cnt_inc == CntSpin);
    cnt_d       = jump ? cnt_inc : cnt_base;
    spin_d      = spin_base || new_period;
    period_d    = new_period ? since : period_q;
    last_jump_d = jump ? s1_stamp_q : last_jump_q;
    for (int i = 0; i < 3; i++) begin
      jump_pos_d[i] = jump ? s1_pos_q[i] : jump_pos_q[i];
      prev_pos_d[i] = s1_track_q ? s1_pos_q[i] : prev_pos_q[i];
    end

    // with a fresh period the ratio test reduces to ratio above one
    if (new_period) begin
      follow = (since != '0) && (follow_ratio_q > RatioOne);
    end else begin
      follow = follow_lhs < follow_rhs;
    end
    fire_diff = $signed({2'b00, period_d}) - $signed({2'b00, since});

    hold = 1'b0;
    fire = s1_track_q;
    for (int i = 0; i < 3; i++) begin
      res_pos[i] = s1_pos_q[i];
    end
    if (spin_d) begin
      if (follow) begin
        fire = 1'b1;
      end else begin
        hold = 1'b1;
        fire = fire_diff < $signed({{(TimeW+2-LimitW){1'b0}}, fire_delay_q});
        for (int i = 0; i < 3; i++) begin
          res_pos[i] = jump_pos_d[i];
        end
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jump_dist_q    <= JumpDistanceRst;
      period_limit_q <= PeriodLimitRst;
      follow_ratio_q <= FollowRatioRst;
      fire_delay_q   <= FireDelayRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgJumpDistance: jump_dist_q    <= cfg_data_i[DistW-1:0];
        CfgPeriodLimit:  period_limit_q <= cfg_data_i[LimitW-1:0];
        CfgFollowRatio:  follow_ratio_q <= cfg_data_i[RatioW-1:0];
        CfgFireDelay:    fire_delay_q   <= cfg_data_i[LimitW-1:0];
        default: begin
        end
      endcase
    end
  end

  // control and jump state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      last_jump_q <= '0;
      cnt_q       <= '0;
      spin_q      <= 1'b0;
      period_q    <= '0;
      for (int i = 0; i < 3; i++) begin
        jump_pos_q[i] <= '0;
        prev_pos_q[i] <= '0;
      end
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (advance) begin
        last_jump_q <= last_jump_d;
        cnt_q       <= cnt_d;
        spin_q      <= spin_d;
        period_q    <= period_d;
        for (int i = 0; i < 3; i++) begin
          jump_pos_q[i] <= jump_pos_d[i];
          prev_pos_q[i] <= prev_pos_d[i];
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_stamp_q  <= stamp_us_i;
      s1_pos_q[0] <= pos_x_i;
      s1_pos_q[1] <= pos_y_i;
      s1_pos_q[2] <= pos_z_i;
      s1_track_q  <= tracking_i;
    end
    if (advance) begin
      for (int i = 0; i < 3; i++) begin
        res_pos_q[i] <= res_pos[i];
      end
      hold_q       <= hold;
      fire_q       <= fire;
      spin_out_q   <= spin_d;
      period_out_q <= period_d;
      since_out_q  <= since;
    end
  end

  assign out_valid_o              = out_valid_q;
  assign out_x_o                  = res_pos_q[0];
  assign out_y_o                  = res_pos_q[1];
  assign out_z_o                  = res_pos_q[2];
  assign hold_and_zero_velocity_o = hold_q;
  assign suggest_fire_o           = fire_q;
  assign spinning_o               = spin_out_q;
  assign period_us_o              = period_out_q;
  assign since_jump_us_o          = since_out_q;

  a_spin_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    spin_q |-> (cnt_q == CntSpin))
    else $error("spin flag set without two counted jumps");

  a_count_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntSpin)
    else $error("jump counter beyond saturation");

  a_hold_needs_spin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && hold_q) |-> spin_out_q)
    else $error("hold reported while not spinning");

  a_advance_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("result lost after advance");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |-> (!s1_valid_q || advance))
    else $error("input register overwritten");

endmodule

`default_nettype wire

// ===== bench/tb_spin_jump_observer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_spin_jump_observer: self-checking bench for the spin jump observer
// Drives target reports through the valid/ready input with bursts and gaps,
// stalls the result side, predicts every aim word from an independent model
// of jump counting, spin detection, follow window and fire lead, and checks
// each result against the oldest prediction. Several register setups are run,
// extremes included, each written while the block is idle.
// ----------------------------------------------------------------------------

import spj_pkg::*;

typedef struct packed {
  logic [StampW-1:0] stamp;
  pos_t              x;
  pos_t              y;
  pos_t              z;
  logic              tracking;
} report_t;

typedef struct packed {
  pos_t             x;
  pos_t             y;
  pos_t             z;
  logic             hold;
  logic             fire;
  logic             spin;
  logic [TimeW-1:0] period;
  logic [TimeW-1:0] since;
} aim_t;

class aim_predictor;
  logic [DistW-1:0]  jump_mm;
  logic [LimitW-1:0] period_limit;
  logic [RatioW-1:0] follow_ratio;
  logic [LimitW-1:0] fire_lead;

  logic [StampW-1:0] last_jump_at;
  pos_t              jump_pos [3];
  pos_t              prev_pos [3];
  int unsigned       jump_count;
  bit                spin;
  logic [TimeW-1:0]  period;

  aim_t        pending_aims [$];
  int unsigned mismatches;
  int unsigned jumps_seen;
  int unsigned holds_seen;
  int unsigned follows_seen;

  function new();
    jump_mm      = JumpDistanceRst;
    period_limit = PeriodLimitRst;
    follow_ratio = FollowRatioRst;
    fire_lead    = FireDelayRst;
    last_jump_at = '0;
    foreach (jump_pos[i]) begin
      jump_pos[i] = '0;
      prev_pos[i] = '0;
    end
    jump_count   = 0;
    spin         = 1'b0;
    period       = '0;
    mismatches   = 0;
    jumps_seen   = 0;
    holds_seen   = 0;
    follows_seen = 0;
  endfunction

  function void set_reg(cfg_idx_e idx, logic [CfgW-1:0] value);
    case (idx)
      CfgJumpDistance: jump_mm      = value[DistW-1:0];
      CfgPeriodLimit:  period_limit = value[LimitW-1:0];
      CfgFollowRatio:  follow_ratio = value[RatioW-1:0];
      CfgFireDelay:    fire_lead    = value[LimitW-1:0];
      default: ;
    endcase
  endfunction

  function void note_report(report_t r);
    pos_t              p [3];
    logic [StampW-1:0] elapsed;
    logic [TimeW-1:0]  since;
    longint            d;
    longint            dist2;
    longint            thr2;
    logic [63:0]       lhs;
    logic [63:0]       rhs;
    longint            lead_left;
    aim_t              a;
    p[0] = r.x;
    p[1] = r.y;
    p[2] = r.z;
    elapsed = (r.stamp >= last_jump_at) ? r.stamp - last_jump_at : '0;
    since   = (|elapsed[StampW-1:TimeW]) ? '1 : elapsed[TimeW-1:0];

    if (since > {8'd0, period_limit}) begin
      spin       = 1'b0;
      jump_count = 0;
    end

    if (r.tracking) begin
      dist2 = 0;
      for (int i = 0; i < 3; i++) begin
        d     = longint'(p[i]) - longint'(prev_pos[i]);
        dist2 = dist2 + d * d;
      end
      thr2 = longint'({48'd0, jump_mm}) * longint'({48'd0, jump_mm});
      if (dist2 > thr2) begin
        jumps_seen++;
        if (jump_count < 2) jump_count++;
        if (jump_count > 1) begin
          spin   = 1'b1;
          period = since;
        end
        last_jump_at = r.stamp;
        foreach (jump_pos[i]) jump_pos[i] = p[i];
      end
      foreach (prev_pos[i]) prev_pos[i] = p[i];
    end

    a.x    = p[0];
    a.y    = p[1];
    a.z    = p[2];
    a.hold = 1'b0;
    if (spin) begin
      lhs = {24'd0, since, 8'd0};
      rhs = {48'd0, follow_ratio} * {32'd0, period};
      if (lhs < rhs) begin
        a.fire = 1'b1;
        follows_seen++;
      end else begin
        a.hold    = 1'b1;
        a.x       = jump_pos[0];
        a.y       = jump_pos[1];
        a.z       = jump_pos[2];
        lead_left = longint'({32'd0, period}) - longint'({32'd0, since});
        a.fire    = lead_left < longint'({40'd0, fire_lead});
        holds_seen++;
      end
    end else begin
      a.fire = r.tracking;
    end
    a.spin   = spin;
    a.period = period;
    a.since  = since;
    pending_aims.push_back(a);
  endfunction

  function void check_aim(aim_t got);
    aim_t exp;
    bit   ok;
    if (pending_aims.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] result word with no report pending", $realtime);
      return;
    end
    exp = pending_aims.pop_front();
    ok = (got.x === exp.x) && (got.y === exp.y) && (got.z === exp.z) &&
         (got.hold === exp.hold) && (got.fire === exp.fire) &&
         (got.spin === exp.spin) && (got.period === exp.period) &&
         (got.since === exp.since);
    if (!ok) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("[%0t] mismatch exp: x=%0d y=%0d z=%0d hold=%b fire=%b spin=%b per=%0d since=%0d",
                 $realtime, exp.x, exp.y, exp.z, exp.hold, exp.fire, exp.spin, exp.period,
                 exp.since);
        $display("[%0t] mismatch got: x=%0d y=%0d z=%0d hold=%b fire=%b spin=%b per=%0d since=%0d",
                 $realtime, got.x, got.y, got.z, got.hold, got.fire, got.spin, got.period,
                 got.since);
      end
    end
  endfunction
endclass

module tb_spin_jump_observer;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned HoldOffCycles = 60;
  localparam int unsigned Phases        = 8;
  localparam int unsigned PhaseItems    = 173;

  typedef enum int {RxFull, RxRandom, RxPattern, RxSparse} rx_mode_e;

  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                cfg_we_i   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i  = '0;
  logic [CfgW-1:0]     cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [StampW-1:0]   stamp_us_i = '0;
  pos_t                pos_x_i    = '0;
  pos_t                pos_y_i    = '0;
  pos_t                pos_z_i    = '0;
  logic                tracking_i = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  pos_t                out_x_o;
  pos_t                out_y_o;
  pos_t                out_z_o;
  logic                hold_and_zero_velocity_o;
  logic                suggest_fire_o;
  logic                spinning_o;
  logic [TimeW-1:0]    period_us_o;
  logic [TimeW-1:0]    since_jump_us_o;

  aim_predictor      predictor;
  rx_mode_e          rx_mode      = RxFull;
  logic              hold_off_tog = 1'b0;
  logic              hold_off_seen = 1'b0;
  int unsigned       hold_off_left = 0;
  int unsigned       rx_tick       = 0;
  int unsigned       quiet_cycles  = 0;
  int unsigned       reports_sent  = 0;

  // sender pacing and report generator state
  int unsigned       burst_left = 0;
  int unsigned       gap_max    = 0;
  logic [StampW-1:0] now_us     = '0;
  int unsigned       cur_dist   = 300;
  int unsigned       cur_limit  = 1000000;
  int unsigned       seq_left   = 0;
  int unsigned       seq_pos    = 0;
  int unsigned       seq_every  = 2;
  int unsigned       base_dt    = 1;
  bit                seq_noise  = 1'b0;
  bit                seq_side   = 1'b0;
  int                side_a [3];
  int                side_b [3];

  spin_jump_observer u_dut (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .cfg_we_i                 (cfg_we_i),
    .cfg_idx_i                (cfg_idx_i),
    .cfg_data_i               (cfg_data_i),
    .in_valid_i               (in_valid_i),
    .in_ready_o               (in_ready_o),
    .stamp_us_i               (stamp_us_i),
    .pos_x_i                  (pos_x_i),
    .pos_y_i                  (pos_y_i),
    .pos_z_i                  (pos_z_i),
    .tracking_i               (tracking_i),
    .out_valid_o              (out_valid_o),
    .out_ready_i              (out_ready_i),
    .out_x_o                  (out_x_o),
    .out_y_o                  (out_y_o),
    .out_z_o                  (out_z_o),
    .hold_and_zero_velocity_o (hold_and_zero_velocity_o),
    .suggest_fire_o           (suggest_fire_o),
    .spinning_o               (spinning_o),
    .period_us_o              (period_us_o),
    .since_jump_us_o          (since_jump_us_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (hold_off_tog != hold_off_seen) begin
      hold_off_seen <= hold_off_tog;
      hold_off_left <= HoldOffCycles;
      out_ready_i   <= 1'b0;
    end else if (hold_off_left > 0) begin
      hold_off_left <= hold_off_left - 1;
      out_ready_i   <= 1'b0;
    end else begin
      rx_tick <= rx_tick + 1;
      case (rx_mode)
        RxFull:    out_ready_i <= 1'b1;
        RxRandom:  out_ready_i <= ($urandom_range(0, 3) != 0);
        RxPattern: out_ready_i <= ((rx_tick % 5) < 3);
        default:   out_ready_i <= $urandom_range(0, 1);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      predictor.check_aim('{x: out_x_o, y: out_y_o, z: out_z_o,
                            hold: hold_and_zero_velocity_o, fire: suggest_fire_o,
                            spin: spinning_o, period: period_us_o,
                            since: since_jump_us_o});
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < WatchdogLimit) @(posedge clk_i);
    $display("timeout: no word moved for %0d cycles", WatchdogLimit);
    $display("FAIL spin_jump_observer");
    $finish;
  end

  function automatic pos_t clamp_pos(int v);
    if (v > 32767) return pos_t'(32767);
    if (v < -32768) return pos_t'(-32768);
    return pos_t'(v);
  endfunction

  function automatic report_t mk(logic [StampW-1:0] s, int x, int y, int z, bit t);
    report_t r;
    r.stamp    = s;
    r.x        = clamp_pos(x);
    r.y        = clamp_pos(y);
    r.z        = clamp_pos(z);
    r.tracking = t;
    return r;
  endfunction

  task automatic offer_now(report_t r);
    in_valid_i <= 1'b1;
    stamp_us_i <= r.stamp;
    pos_x_i    <= r.x;
    pos_y_i    <= r.y;
    pos_z_i    <= r.z;
    tracking_i <= r.tracking;
    do @(posedge clk_i); while (!in_ready_o);
    predictor.note_report(r);
    reports_sent++;
  endtask

  task automatic offer_report(report_t r);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    offer_now(r);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (predictor.pending_aims.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_config(logic [CfgW-1:0] jump_dist, logic [CfgW-1:0] limit,
                              logic [CfgW-1:0] ratio, logic [CfgW-1:0] lead);
    logic [CfgW-1:0] vals [4];
    cfg_idx_e        idx;
    vals[CfgJumpDistance] = jump_dist;
    vals[CfgPeriodLimit]  = limit;
    vals[CfgFollowRatio]  = ratio;
    vals[CfgFireDelay]    = lead;
    idx = idx.first();
    do begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx;
      cfg_data_i <= vals[idx];
      predictor.set_reg(idx, vals[idx]);
      @(posedge clk_i);
      idx = idx.next();
    end while (idx != idx.first());
    cfg_we_i  <= 1'b0;
    cur_dist  = jump_dist[DistW-1:0];
    cur_limit = limit[LimitW-1:0];
  endtask

  task automatic start_sequence();
    int unsigned ax;
    int          sep;
    seq_noise = ($urandom_range(0, 9) < 3);
    seq_left  = seq_noise ? $urandom_range(1, 4) : $urandom_range(8, 30);
    seq_pos   = 0;
    seq_every = $urandom_range(2, 6);
    base_dt   = (cur_limit / 100) * $urandom_range(20, 120) / seq_every;
    if (base_dt == 0) base_dt = 1;
    sep = int'(cur_dist) + $urandom_range(0, 60) - 20;
    if (sep > 30000) begin
      foreach (side_a[i]) begin
        side_a[i] = -32768 + $urandom_range(0, 100);
        side_b[i] = 32767 - $urandom_range(0, 100);
      end
    end else begin
      ax = $urandom_range(0, 2);
      foreach (side_a[i]) begin
        side_a[i] = $urandom_range(0, 32000) - 16000;
        side_b[i] = side_a[i];
      end
      side_b[ax] = side_a[ax] + sep;
    end
  endtask

  task automatic make_report(output report_t r);
    int unsigned lo;
    if (seq_left == 0) start_sequence();
    seq_left--;
    if (seq_noise) begin
      case ($urandom_range(0, 9))
        0:       now_us = {16'($urandom_range(0, 65535)), 32'($urandom)};
        1:       now_us = now_us - $urandom_range(1, 5000);
        2:       now_us = now_us + {16'd1, 32'($urandom)};
        default: now_us = now_us + $urandom_range(0, 2 * base_dt);
      endcase
      r.stamp    = now_us;
      r.x        = pos_t'($urandom);
      r.y        = pos_t'($urandom);
      r.z        = pos_t'($urandom);
      r.tracking = $urandom_range(0, 1);
    end else begin
      if (seq_pos % seq_every == 0) seq_side = ~seq_side;
      seq_pos++;
      lo = base_dt / 2;
      now_us = now_us + $urandom_range(lo, base_dt + lo);
      r.stamp    = now_us;
      r.x        = clamp_pos((seq_side ? side_b[0] : side_a[0]) + $urandom_range(0, 10) - 5);
      r.y        = clamp_pos((seq_side ? side_b[1] : side_a[1]) + $urandom_range(0, 10) - 5);
      r.z        = clamp_pos((seq_side ? side_b[2] : side_a[2]) + $urandom_range(0, 10) - 5);
      r.tracking = ($urandom_range(0, 19) != 0);
    end
  endtask

  initial begin
    report_t         plan [$];
    report_t         r;
    logic [CfgW-1:0] jump_dist;
    logic [CfgW-1:0] limit;
    logic [CfgW-1:0] ratio;
    logic [CfgW-1:0] lead;
    predictor = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // at threshold, first jump, second jump and spin, follow, hold, negative
    // fire lead, stamp going back, saturated time, idle tracker, max stamps
    plan.push_back(mk(0, 0, 0, 0, 1));
    plan.push_back(mk(1000, 300, 0, 0, 1));
    plan.push_back(mk(2000, 601, 0, 0, 1));
    plan.push_back(mk(3000, 0, 0, 0, 0));
    plan.push_back(mk(500000, -32768, -32768, -32768, 1));
    plan.push_back(mk(520000, -32768, -32768, -32768, 1));
    plan.push_back(mk(900000, -32768, -32768, -32768, 0));
    plan.push_back(mk(920000, -32768, -32768, -32768, 1));
    plan.push_back(mk(1100000, -32768, -32768, -32768, 1));
    plan.push_back(mk(100000, 32767, 32767, 32767, 1));
    plan.push_back(mk(120000, 32767, 32767, 32767, 1));
    plan.push_back(mk(48'hFFFF_FFFF_FFFF, 32767, 32767, 32767, 0));
    plan.push_back(mk(48'hFFFF_FFFF_FFFF, -32768, 0, 32767, 1));
    plan.push_back(mk(0, 0, -32768, 0, 1));
    plan.push_back(mk(48'hAAAA_5555_AAAA, 21845, -21846, 0, 1));
    plan.push_back(mk(48'h5555_AAAA_5555, -21846, 21845, -1, 1));
    plan.push_back(mk(48'h5555_AAAA_5556, -21846, 21845, -1, 0));

    for (int unsigned phase = 0; phase < Phases; phase++) begin
      case (phase)
        1: begin
          jump_dist = 0; limit = 24'hFF_FFFF; ratio = 16'hFFFF; lead = 0;
        end
        2: begin
          jump_dist = 16'hFFFF; limit = 0; ratio = 0; lead = 24'hFF_FFFF;
        end
        3: begin
          jump_dist = 1000; limit = 50000; ratio = RatioOne; lead = 10000;
        end
        0, 7: begin
          jump_dist = JumpDistanceRst; limit = PeriodLimitRst;
          ratio = FollowRatioRst; lead = FireDelayRst;
        end
        default: begin
          jump_dist = $urandom_range(50, 2000);
          limit     = $urandom_range(1000, 2000000);
          ratio     = $urandom_range(0, 512);
          lead      = $urandom_range(0, limit);
        end
      endcase
      drain();
      write_config(jump_dist, limit, ratio, lead);
      case (phase % 4)
        0:       rx_mode <= RxRandom;
        1:       rx_mode <= RxPattern;
        2:       rx_mode <= RxSparse;
        default: rx_mode <= RxFull;
      endcase
      gap_max = (phase % 3 == 2) ? 0 : 1 + (phase % 4) * 2;
      if (phase == 7) begin
        gap_max = 0;
      end
      if (phase == 0) begin
        foreach (plan[i]) offer_report(plan[i]);
      end
      for (int unsigned i = 0; i < PhaseItems; i++) begin
        if (phase == 2 && i == 60) begin
          // receiver holds off while the sender keeps pushing
          hold_off_tog <= ~hold_off_tog;
          repeat (12) begin
            make_report(r);
            offer_now(r);
          end
        end
        if (phase == 4 && i == 80) drain();
        make_report(r);
        offer_report(r);
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (predictor.pending_aims.size() != 0) begin
      predictor.mismatches++;
      $display("%0d results never arrived", predictor.pending_aims.size());
    end
    $display("ran %0d reports over %0d register setups: %0d jumps, %0d held, %0d follow",
             reports_sent, Phases, predictor.jumps_seen, predictor.holds_seen,
             predictor.follows_seen);
    $display("result words failing the check: %0d", predictor.mismatches);
    if (predictor.mismatches == 0) begin
      $display("PASS spin_jump_observer");
    end else begin
      $display("FAIL spin_jump_observer");
    end
    $finish;
  end

endmodule

// ===== spin_jump_observer.f =====
rtl/core/spj_pkg.sv
rtl/core/spin_jump_observer.sv
bench/tb_spin_jump_observer.sv
